/* rtl/svwm_pkg.sv */
// Shared types and constants of the supply voltage window monitor.
package svwm_pkg;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_UNDER   = 2'd1,
		ST_OVER    = 2'd2,
		ST_INITIAL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_UNDER_RELEASE = 3'd0,
		CFG_UNDER_RECOVER = 3'd1,
		CFG_OVER_RECOVER  = 3'd2,
		CFG_OVER_TRIP     = 3'd3,
		CFG_DEBOUNCE      = 3'd4
	} cfg_index_t;

	localparam int CFG_DATA_W = 16;
	localparam int MV_OUT_W   = 16;
	localparam int DEB_W      = 7;
	localparam int LEFT_W     = 8;

	// Millivolts are floor(sample * 125 / 14), taken as floor(sample * SCALE_MULT >> SCALE_SHIFT).
	// The reciprocal is exact for every sample below two million.
	localparam int              SCALE_SHIFT = 24;
	localparam int              SCALE_MULT_W = 28;
	localparam logic [27:0]     SCALE_MULT  = 28'd149796572;

	localparam logic [15:0] UNDER_RELEASE_RST = 16'd6000;
	localparam logic [15:0] UNDER_RECOVER_RST = 16'd6500;
	localparam logic [15:0] OVER_RECOVER_RST  = 16'd28000;
	localparam logic [15:0] OVER_TRIP_RST     = 16'd28500;
	localparam logic [6:0]  DEBOUNCE_RST      = 7'd5;

	typedef struct packed {
		logic [15:0] under_release;
		logic [15:0] under_recover;
		logic [15:0] over_recover;
		logic [15:0] over_trip;
		logic [6:0]  debounce_count;
	} cfg_t;

endpackage

/* rtl/svwm_if.sv */
// Handshake interfaces for the sample and result channels.
interface svwm_sample_if #(parameter int ADC_BITS = 12);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_sample;
	modport source(output valid, output adc_sample, input ready);
	modport sink(input valid, input adc_sample, output ready);
endinterface

interface svwm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] voltage_mv;
	logic [1:0]  supply_status;
	modport source(output valid, output voltage_mv, output supply_status, input ready);
	modport sink(input valid, input voltage_mv, input supply_status, output ready);
endinterface

/* rtl/svwm_front.sv */
// Front stage: accepts samples and scales them to millivolts.
module svwm_front #(
	parameter int ADC_BITS = 12,
	parameter int MV_W     = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	svwm_sample_if.sink         sample,
	output logic                push_valid,
	output logic [MV_W-1:0]     push_data,
	input  logic                push_ready
);
	import svwm_pkg::*;

	localparam int PROD_W = SCALE_SHIFT + MV_W;

	logic                valid_s1;
	logic [MV_W-1:0]     mv_s1;
	logic [PROD_W-1:0]   prod;
	logic                take;

	assign sample.ready = !valid_s1 || push_ready;
	assign take         = sample.valid && sample.ready;
	assign prod         = PROD_W'(sample.adc_sample) * PROD_W'(SCALE_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mv_s1 <= prod[SCALE_SHIFT +: MV_W];
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = mv_s1;
endmodule

/* rtl/svwm_fifo.sv */
// Two-word queue between the front and back stages.
module svwm_fifo #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data,
	input  logic             pop
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

/* rtl/svwm_back.sv */
// Back stage: window classification, debounce and the result register.
module svwm_back #(
	parameter int MV_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  svwm_pkg::cfg_t    cfg,
	input  logic              pop_valid,
	input  logic [MV_W-1:0]   pop_data,
	output logic              pop,
	svwm_result_if.source     result
);
	import svwm_pkg::*;

	status_t              status_q;
	logic [LEFT_W-1:0]    left_q;
	logic                 out_valid_q;
	logic [MV_OUT_W-1:0]  out_mv_q;
	status_t              out_status_q;

	logic [15:0]          lo;
	logic [15:0]          hi;
	status_t              cls;
	logic                 differs;
	logic                 adopt;
	logic [LEFT_W-1:0]    reload;

	assign pop    = pop_valid && (!out_valid_q || result.ready);
	assign reload = LEFT_W'(cfg.debounce_count);

	always_comb begin
		case (status_q)
			ST_UNDER: begin
				lo = cfg.under_recover;
				hi = cfg.over_trip;
			end
			ST_OVER: begin
				lo = cfg.under_release;
				hi = cfg.over_recover;
			end
			default: begin
				lo = cfg.under_release;
				hi = cfg.over_trip;
			end
		endcase
		if (pop_data < MV_W'(lo)) begin
			cls = ST_UNDER;
		end else if (pop_data > MV_W'(hi)) begin
			cls = ST_OVER;
		end else begin
			cls = ST_NORMAL;
		end
		differs = (cls != status_q);
		adopt   = (status_q == ST_INITIAL) || (differs && left_q <= LEFT_W'(1))
			|| (!differs && reload == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= ST_INITIAL;
			left_q      <= LEFT_W'(DEBOUNCE_RST);
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (adopt) begin
					status_q <= cls;
					left_q   <= reload;
				end else if (differs) begin
					left_q <= left_q - LEFT_W'(1);
				end else begin
					left_q <= reload;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_mv_q     <= (pop_data > MV_W'(16'hFFFF)) ? 16'hFFFF : pop_data[MV_OUT_W-1:0];
			out_status_q <= adopt ? cls : status_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.voltage_mv    = out_mv_q;
	assign result.supply_status = out_status_q;
endmodule

/* rtl/supply_voltage_window_monitor.sv */
// Top level of the supply voltage window monitor with its register file.
//
// The sample channel takes one raw converter word per handshake; only the low
// ADC_BITS bits are used. Each word is scaled to millivolts as
// sample * 1000 / 112, rounded down, and yields exactly one result word on the
// result channel carrying the scaled voltage (saturated at 65535) and the
// debounced status: normal, under voltage or over voltage.
// The front stage registers the scaled word, a two-word queue follows, and the
// back stage classifies against the hysteresis limits, runs the debounce
// countdown and holds the result in an output register.
// A word accepted on the sample channel passes through the front register, the
// queue and the output register to the result channel. The block takes one word
// per cycle if the receiver is ready, set by the back-stage status update loop.
// When the receiver stalls, the output register holds its word and the queue
// and front register fill; the sample channel drops ready only when all are full.
// Reset clears the channels, loads the register defaults and marks the status as
// not yet classified, so the first sample is adopted at once. The user must write
// registers through cfg_we, cfg_index and cfg_data only while idle; not enforced.
module supply_voltage_window_monitor #(
	parameter int ADC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	svwm_sample_if.sink                         sample,
	svwm_result_if.source                       result,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [svwm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import svwm_pkg::*;

	localparam int MV_W = (ADC_BITS + 4 > MV_OUT_W) ? ADC_BITS + 4 : MV_OUT_W;

	cfg_t            cfg_q;
	logic            push_valid;
	logic [MV_W-1:0] push_data;
	logic            push_ready;
	logic            pop_valid;
	logic [MV_W-1:0] pop_data;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.under_release  <= UNDER_RELEASE_RST;
			cfg_q.under_recover  <= UNDER_RECOVER_RST;
			cfg_q.over_recover   <= OVER_RECOVER_RST;
			cfg_q.over_trip      <= OVER_TRIP_RST;
			cfg_q.debounce_count <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UNDER_RELEASE: cfg_q.under_release  <= cfg_data;
				CFG_UNDER_RECOVER: cfg_q.under_recover  <= cfg_data;
				CFG_OVER_RECOVER:  cfg_q.over_recover   <= cfg_data;
				CFG_OVER_TRIP:     cfg_q.over_trip      <= cfg_data;
				CFG_DEBOUNCE:      cfg_q.debounce_count <= cfg_data[DEB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	svwm_front #(
		.ADC_BITS (ADC_BITS),
		.MV_W     (MV_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	svwm_fifo #(
		.WIDTH (MV_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	svwm_back #(
		.MV_W (MV_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop       (pop),
		.result    (result)
	);
endmodule
